### src/r50_pkg.sv
// r50_pkg: types, character codes and helper functions for the radix-50 symbol encoder.
// No dependencies. Used by r50_store, r50_pack and radix50_symbol_encoder_core.
`timescale 1ns / 1ps
`default_nettype none

package r50_pkg;

  // Number of character slots in one packed symbol
  localparam int unsigned SLOTS = 5;
  // Bits needed to hold a slot count of 0..SLOTS
  localparam int unsigned CNT_W = 3;

  typedef logic [5:0] code_t;
  typedef logic [SLOTS-1:0][5:0] codes_t;
  typedef logic [CNT_W-1:0] count_t;

  // One update of the character store
  typedef struct packed {
    logic  en;    // a word moves out of the input register
    logic  term;  // the word is the zero terminator
    code_t code;  // mapped code, CODE_NONE if skipped
  } step_t;

  // Input byte values
  localparam logic [7:0] CH_TERM  = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // Codes
  localparam code_t CODE_NONE     = 6'd0;
  localparam logic [7:0] CODE_DIGIT0   = 8'd1;
  localparam logic [7:0] CODE_LETTER_A = 8'd11;
  localparam code_t CODE_DOT      = 6'd37;
  localparam code_t CODE_QMARK    = 6'd38;

  // Map one byte to its base-forty code, CODE_NONE for bytes that are skipped
  function automatic code_t map_char(input logic [7:0] ch);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        t = ch - CH_ZERO + CODE_DIGIT0;
      end else if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
        t = ch - CH_UP_A + CODE_LETTER_A;
      end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
        t = ch - CH_LO_A + CODE_LETTER_A;
      end else if (ch == CH_DOT) begin
        t = {2'b00, CODE_DOT};
      end else if (ch == CH_QMARK) begin
        t = {2'b00, CODE_QMARK};
      end
      return t[5:0];
    end
  endfunction

  // x * 40 as (x << 5) + (x << 3)
  function automatic logic [15:0] mul40(input logic [10:0] x);
    logic [15:0] w;
    begin
      w = {5'b00000, x};
      return (w << 5) + (w << 3);
    end
  endfunction

endpackage

`default_nettype wire

### src/r50_store.sv
// r50_store: five-slot character code store with fill count.
// Depends on r50_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r50_store (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire r50_pkg::step_t step,
  output r50_pkg::codes_t     codes,
  output r50_pkg::count_t     count
);
  import r50_pkg::*;

  codes_t codes_next;
  count_t count_next;

  // Next store contents: clear on terminator, append mapped code while room
  always_comb begin
    codes_next = codes;
    count_next = count;
    if (step.en) begin
      if (step.term) begin
        codes_next = '0;
        count_next = '0;
      end else if (step.code != CODE_NONE && count < count_t'(SLOTS)) begin
        codes_next[count] = step.code;
        count_next = count + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      codes <= '0;
      count <= '0;
    end else begin
      codes <= codes_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

### src/r50_pack.sv
// r50_pack: packs five codes base forty into two 16-bit words with flags.
// Depends on r50_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r50_pack (
  input  wire r50_pkg::codes_t codes,
  input  wire logic [4:0]      flags,
  output logic [15:0]          high_word,
  output logic [15:0]          low_word
);
  import r50_pkg::*;

  logic [15:0] c01;
  logic [15:0] c34;

  // high = (c0*40 + c1)*40 + c2, low = (c3*40 + c4) << 5 | flags
  always_comb begin
    c01 = mul40({5'b00000, codes[0]}) + {10'd0, codes[1]};
    high_word = mul40(c01[10:0]) + {10'd0, codes[2]};
    c34 = mul40({5'b00000, codes[3]}) + {10'd0, codes[4]};
    low_word = {c34[10:0], flags};
  end

endmodule

`default_nettype wire

### src/radix50_symbol_encoder_core.sv
// Radix-50 symbol encoder: one character byte per word in, one packed symbol per terminator.
// Path: a terminator word goes from the input register, once the output slot is free, into the output register.
// Throughput: one word per cycle; the input register is freed every cycle unless a
// terminator waits for the output register to be taken.
// Reset (rst, synchronous): empties input and output registers and clears the code store.
// Depends on r50_pkg, r50_store, r50_pack.
`timescale 1ns / 1ps
`default_nettype none

module radix50_symbol_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  char_in,
  input  wire logic [4:0]  flag_bits,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic [15:0]      high_word,
  output logic [15:0]      low_word,
  output logic             out_valid,
  input  wire logic        out_ready
);
  import r50_pkg::*;

  // Input register
  logic        in_full;
  logic [7:0]  char_q;
  logic [4:0]  flags_q;

  logic        is_term;
  logic        out_free;
  logic        adv;
  logic        load;
  step_t       step;
  codes_t      codes;
  count_t      count;
  logic [15:0] pack_high;
  logic [15:0] pack_low;

  // Handshake: a character always moves on; a terminator needs the output slot
  assign is_term  = (char_q == CH_TERM);
  assign out_free = !out_valid || out_ready;
  assign adv      = in_full && (!is_term || out_free);
  assign load     = adv && is_term;
  assign in_ready = !in_full || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q  <= char_in;
      flags_q <= flag_bits;
    end
  end

  // Store update
  always_comb begin
    step.en   = adv;
    step.term = is_term;
    step.code = map_char(char_q);
  end

  r50_store u_store (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .codes (codes),
    .count (count)
  );

  r50_pack u_pack (
    .codes     (codes),
    .flags     (flags_q),
    .high_word (pack_high),
    .low_word  (pack_low)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      high_word <= pack_high;
      low_word  <= pack_low;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(SLOTS))
    else $error("code store count above slot count");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    load |=> (count == '0) && (codes == '0))
    else $error("store not cleared after terminator");

  a_term_emits: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && (low_word[4:0] == $past(flags_q)))
    else $error("terminator did not produce a word with its flags");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("output register loaded while holding an untaken word");

endmodule

`default_nettype wire
